FILE: sv/signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the signed integer to decimal ASCII converter.
// Used by the datapath and controller; expects clk and rst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sida: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sida: next-cycle check failed");

`endif

FILE: sv/sida_pkg.sv
// Shared constants, types and helpers for the decimal ASCII converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sida_pkg;

    localparam int DATA_W   = 32;
    localparam int DIGITS   = 10;
    localparam int NIB_W    = 4;
    localparam int BCD_W    = DIGITS * NIB_W;
    localparam int POS_W    = $clog2(DIGITS);
    localparam int STEP_W   = $clog2(DATA_W);
    localparam int CHAR_W   = 6;
    localparam int CNT_W    = 4;

    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DATA_W - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a new value, form magnitude
        logic step;   // one shift-and-adjust iteration
        logic prep;   // locate leading digit, arm sign
        logic emit;   // load next character into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
        logic last_char;  // the next emitted character ends the number
    } status_t;

    // Add-3 correction for one BCD digit ahead of the shift
    function automatic logic [NIB_W-1:0] bcd_adjust(input logic [NIB_W-1:0] nib);
        logic [NIB_W-1:0] res;
        begin
            res = (nib >= NIB_W'(5)) ? nib + NIB_W'(3) : nib;
            return res;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/sida_in_if.sv
// Input channel: one signed 32-bit value per beat.
// Depends on sida_pkg for the data width.
`default_nettype none

interface sida_in_if;
    import sida_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: sv/sida_out_if.sv
// Output channel: one ASCII character per beat with last flag and count.
// Depends on sida_pkg for field widths.
`default_nettype none

interface sida_out_if;
    import sida_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic [CNT_W-1:0]  chars_so_far;

    modport source (output valid, output char_code, output is_last, output chars_so_far,
                    input ready);
    modport sink   (input valid, input char_code, input is_last, input chars_so_far,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII converter.
//
// Usage:
//   value_ch (sink) takes one signed 32-bit integer per beat. char_ch
//   (source) returns its decimal text, one ASCII character per beat: a
//   minus first for negative values, then the digits without leading
//   zeros (zero is a single '0'). Each beat carries is_last on the final
//   character and chars_so_far, the count including the sign.
//   Timing: after an input beat, 32 steps of shift-and-add-3 in the BCD
//   register, a prep step to locate the leading digit, then one character
//   per cycle into the output register while the receiver keeps up. An
//   item has N = 1..11 characters; the output is a single register. A new
//   value is taken as soon as the last character sits in the output
//   register.
//   A stalled receiver holds the output register and the emit sequence.
//   Reset clears the controller and the output valid; no item is pending.
// Depends on sida_pkg, sida_in_if, sida_out_if, sida_ctrl, sida_datapath.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sida_in_if.sink    value_ch,
    sida_out_if.source char_ch
);
    import sida_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign value_ch.ready = in_ready;

    // Sequencer
    sida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (value_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Conversion and output register
    sida_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .value  (value_ch.value),
        .out_ch (char_ch)
    );

endmodule

`default_nettype wire

FILE: sv/sida_datapath.sv
// Datapath: magnitude, double-dabble BCD register, character emitter and
// output register. Depends on sida_pkg, sida_out_if and the assertion macros.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module sida_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire sida_pkg::cmd_t                   cmd,
    output sida_pkg::status_t                     status,
    input  wire logic signed [sida_pkg::DATA_W-1:0] value,
    sida_out_if.source                            out_ch
);
    import sida_pkg::*;

    logic [DATA_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic              neg_reg, neg_next;
    logic              sign_pend_reg, sign_pend_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [NIB_W-1:0]  nib [DIGITS];
    logic [BCD_W-1:0]  bcd_adj;
    logic [POS_W-1:0]  lead_pos;
    logic [NIB_W-1:0]  cur_digit;
    logic [DATA_W-1:0] raw;

    // Split BCD register into digits; adjust each and find the leading one
    always_comb
    begin
        lead_pos = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            nib[i] = bcd_reg[i*NIB_W +: NIB_W];
            bcd_adj[i*NIB_W +: NIB_W] = bcd_adjust(nib[i]);
            if (nib[i] != '0)
            begin
                lead_pos = POS_W'(i);
            end
        end
    end

    assign cur_digit = nib[pos_reg];
    assign raw       = $unsigned(value);

    // Next-state logic for the conversion and emit registers
    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        if (cmd.load)
        begin
            neg_next = raw[DATA_W-1];
            mag_next = raw[DATA_W-1] ? (DATA_W'(0) - raw) : raw;
            bcd_next = '0;
        end
        if (cmd.step)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[DATA_W-1]};
            mag_next = {mag_reg[DATA_W-2:0], 1'b0};
        end
        if (cmd.prep)
        begin
            pos_next       = lead_pos;
            sign_pend_next = neg_reg;
            cnt_next       = '0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_cnt_next   = cnt_reg + CNT_W'(1);
            cnt_next       = cnt_reg + CNT_W'(1);
            if (sign_pend_reg)
            begin
                out_char_next  = CODE_MINUS;
                out_last_next  = 1'b0;
                sign_pend_next = 1'b0;
            end
            else
            begin
                out_char_next = CODE_ZERO + {{(CHAR_W-NIB_W){1'b0}}, cur_digit};
                out_last_next = (pos_reg == '0);
                if (pos_reg != '0)
                begin
                    pos_next = pos_reg - POS_W'(1);
                end
            end
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload flops
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        sign_pend_reg <= sign_pend_next;
        pos_reg       <= pos_next;
        cnt_reg       <= cnt_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign status.out_free  = !out_valid_reg || out_ch.ready;
    assign status.last_char = !sign_pend_reg && (pos_reg == '0);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.char_code    = out_char_reg;
    assign out_ch.is_last      = out_last_reg;
    assign out_ch.chars_so_far = out_cnt_reg;

    // A character is only loaded when the output register has room
    `SIDA_ASSERT_NOW(a_emit_room, cmd.emit, !out_valid_reg || out_ch.ready)
    // The sign beat is a minus and never closes the number
    `SIDA_ASSERT_NEXT(a_sign_beat, cmd.emit && sign_pend_reg,
                      out_char_reg == CODE_MINUS && !out_last_reg)
    // After prep the pointer sits on a nonzero digit or on the units digit
    `SIDA_ASSERT_NEXT(a_lead_digit, cmd.prep, pos_reg == '0 || cur_digit != '0)

endmodule

`default_nettype wire

FILE: sv/sida_ctrl.sv
// Controller FSM: sequences load, 32 conversion steps, prep and emit.
// Depends on sida_pkg and the assertion macros.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module sida_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sida_pkg::status_t status,
    output sida_pkg::cmd_t         cmd
);
    import sida_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_PREP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_char)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // At most one command per cycle
    `SIDA_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.step, cmd.prep, cmd.emit}))
    // A load starts the conversion with the step counter cleared
    `SIDA_ASSERT_NEXT(a_load_start, cmd.load, state_reg == S_CONV && step_reg == '0)
    // The final conversion step hands over to prep
    `SIDA_ASSERT_NEXT(a_conv_end, state_reg == S_CONV && step_reg == LAST_STEP,
                      state_reg == S_PREP)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for signed_int_to_decimal_ascii: drives signed values, checks each ASCII beat.
// Depends on the RTL top and its sida_pkg, sida_in_if and sida_out_if; needs nothing else.
`timescale 1ns / 1ps

module tb;
    import sida_pkg::*;

    localparam int ITEM_COUNT  = 210;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 60;
    localparam int IDLE_PCT    = 27;
    localparam int QUIET_FIRST = 40;
    localparam int QUIET_LAST  = 90;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT    = 170;
    localparam int EDGE_COUNT  = 23;

    localparam int EDGE_VALUES [EDGE_COUNT] = '{
        0, 1, -1, 5, -7, 9, 10, -10, 99, -100, 1000, 65535, -99999, 1000000,
        123456789, -987654321, 1000000000, -1000000000, 1999999999,
        2147483647, 2147483646, -2147483647, -2147483647 - 1
    };

    // One expected character beat
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic [CNT_W-1:0]  count;
    } char_beat_t;

    // Expected character store and checker
    class ascii_scoreboard;
        char_beat_t want_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Spell a value in decimal and queue its characters
        function void note_value(input logic [DATA_W-1:0] raw);
            logic [DATA_W-1:0] mag;
            logic [NIB_W-1:0]  digit [DIGITS];
            logic              neg;
            int                lead;
            int                n;
            int                i;
            char_beat_t        beat;
            neg = raw[DATA_W-1];
            mag = neg ? (~raw + 1'b1) : raw;
            for (i = DIGITS - 1; i >= 0; i--)
            begin
                digit[i] = NIB_W'(mag % 10);
                mag      = mag / 10;
            end
            lead = DIGITS - 1;
            for (i = DIGITS - 1; i >= 0; i--)
            begin
                if (digit[i] != 0)
                    lead = i;
            end
            n = 0;
            if (neg)
            begin
                n++;
                beat = '{code: CODE_MINUS, last: 1'b0, count: CNT_W'(n)};
                want_q.push_back(beat);
            end
            for (i = lead; i < DIGITS; i++)
            begin
                n++;
                beat = '{code: CODE_ZERO + CHAR_W'(digit[i]), last: (i == DIGITS - 1),
                         count: CNT_W'(n)};
                want_q.push_back(beat);
            end
        endfunction

        task check_char(input logic [CHAR_W-1:0] code, input logic last,
                        input logic [CNT_W-1:0] count);
            char_beat_t want;
            if (want_q.size() == 0)
            begin
                report($sformatf("unexpected beat char=%0d last=%0b count=%0d",
                                 code, last, count));
                return;
            end
            want = want_q.pop_front();
            if (code !== want.code || last !== want.last || count !== want.count)
                report($sformatf("got char=%0d last=%0b count=%0d, want %0d/%0b/%0d",
                                 code, last, count, want.code, want.last, want.count));
        endtask

        function int pending();
            return want_q.size();
        endfunction

        task wrap_up();
            if (want_q.size() != 0)
                report($sformatf("%0d expected beats never arrived", want_q.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sida_in_if  value_ch ();
    sida_out_if char_ch ();

    signed_int_to_decimal_ascii uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .char_ch  (char_ch)
    );

    ascii_scoreboard sb = new();

    // Mirrors of scoreboard state, updated at the edge so readers see stable values
    int waiting_beats = 0;
    int inputs_taken  = 0;
    int cycles        = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Monitor: note accepted values, check accepted characters
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (char_ch.valid && char_ch.ready)
                sb.check_char(char_ch.char_code, char_ch.is_last, char_ch.chars_so_far);
            if (value_ch.valid && value_ch.ready)
            begin
                sb.note_value(value_ch.value);
                inputs_taken <= inputs_taken + 1;
            end
            waiting_beats <= sb.pending();
        end
    end

    // Receiver: random stalls, a quiet stretch and one long hold-off
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        char_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                char_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && inputs_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                char_ch.ready <= 1'b0;
            end
            else if (inputs_taken >= QUIET_FIRST && inputs_taken < QUIET_LAST)
                char_ch.ready <= 1'b1;
            else
                char_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Random value: mostly spread over every digit count, some raw 32-bit patterns
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] mag;
        int                n_dig;
        int                i;
        if ($urandom_range(99) < 25)
            return $urandom();
        n_dig = $urandom_range(DIGITS, 1);
        lo = 1;
        for (i = 1; i < n_dig; i++)
            lo = lo * 10;
        hi = (n_dig == DIGITS) ? 32'h7FFF_FFFF : lo * 10 - 1;
        if (n_dig == 1)
            lo = 0;
        mag = $urandom_range(hi, lo);
        return ($urandom_range(1) != 0) ? -mag : mag;
    endfunction

    // Offer one beat, with an optional random gap ahead of it
    task automatic offer_value(input logic [DATA_W-1:0] v, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(99) < IDLE_PCT)
        begin
            value_ch.valid <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge clk);
        while (!value_ch.ready)
            @(posedge clk);
    endtask

    // Sender and end of run
    initial
    begin : sender
        int k;
        rst_n = 1'b0;
        value_ch.valid <= 1'b0;
        value_ch.value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values: extremes, a spread of lengths, both signs
        for (k = 0; k < EDGE_COUNT; k++)
            offer_value(DATA_W'(EDGE_VALUES[k]), 1'b1);

        for (k = 0; k < ITEM_COUNT; k++)
        begin
            // Let the pipeline drain completely once
            if (k == DRAIN_AT)
            begin
                value_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (waiting_beats != 0);
            end
            offer_value(pick_value(), !(k >= QUIET_FIRST && k < QUIET_LAST));
        end
        value_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (waiting_beats != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.wrap_up();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/sida_pkg.sv
sv/sida_in_if.sv
sv/sida_out_if.sv
sv/sida_datapath.sv
sv/sida_ctrl.sv
sv/signed_int_to_decimal_ascii.sv
tb/tb.sv
